### hdl/akf_pkg.sv
// Package for the two-state altitude Kalman filter core.
// Holds Q16.16 constants, register indexes, sequencer states and saturating helpers.
// No dependencies.
package akf_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned DtWidth = 18;

  localparam logic signed [31:0] QOne  = 32'sd65536;
  localparam logic signed [31:0] QHalf = 32'sd32768;
  localparam logic signed [31:0] SFloor = 32'sd7;

  typedef enum logic [2:0] {
    REG_TRANS_00  = 3'd0,
    REG_TRANS_01  = 3'd1,
    REG_TRANS_10  = 3'd2,
    REG_TRANS_11  = 3'd3,
    REG_NOISE_00  = 3'd4,
    REG_NOISE_01  = 3'd5,
    REG_NOISE_11  = 3'd6,
    REG_MEAS_VAR  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DIV,
    ST_OUT
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    qadd = sat32(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    qsub = sat32(66'(a) - 66'(b));
  endfunction

  // Round half up and saturate a registered 64-bit product.
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [65:0] r;
    r = (66'(p) + 66'sd32768) >>> 16;
    qround = sat32(r);
  endfunction

endpackage

### hdl/akf_if.sv
// Valid/ready channel interfaces for the altitude Kalman filter core.
// Depends on akf_pkg.
interface akf_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [17:0] time_step;
  logic signed [31:0] accel;
  logic signed [31:0] meas_altitude;
  modport source (output valid, req_type, time_step, accel, meas_altitude, input ready);
  modport sink (input valid, req_type, time_step, accel, meas_altitude, output ready);
endinterface

interface akf_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] altitude;
  logic signed [31:0] velocity;
  logic signed [31:0] altitude_var;
  modport source (output valid, altitude, velocity, altitude_var, input ready);
  modport sink (input valid, altitude, velocity, altitude_var, output ready);
endinterface

interface akf_cfg_if;
  logic        valid;
  logic        ready;
  logic [akf_pkg::CfgIdxWidth-1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/altitude_kalman_filter_2state_core.sv
// Predict runs the multiply schedule from accept to result valid; update runs
// two 48-step restoring divisions on one shared divider, then multiplies.
// One word in flight at a time; in_ready is low from accept until the result
// word is taken, so no new word is accepted while one is in flight.
// The shared divider sets the update rate, the 32x32 multiplier the predict rate.
// Asynchronous active-low reset restores F = I, Q = 0, R = 1.0, state and P = 0.
module altitude_kalman_filter_2state_core (
  input logic clk_i,
  input logic rst_ni,
  akf_in_if.sink   in_ch,
  akf_out_if.source out_ch,
  akf_cfg_if.sink  cfg_ch
);

  // Configuration registers, always writable (host writes only while idle; the core does not enforce this).
  logic signed [31:0] f00_q, f01_q, f10_q, f11_q, q00_q, q01_q, q11_q, r_q;
  // Filter state.
  logic signed [31:0] alt_q, vel_q, p00_q, p01_q, p10_q, p11_q;
  // Latched request.
  logic        kind_q;
  logic signed [31:0] dt_q, acc_q, meas_q;
  // Scratch registers for intermediate products.
  logic signed [31:0] t0_q, t1_q, t2_q, t3_q, t4_q, t5_q, t6_q, t7_q;
  logic signed [31:0] k0_q, k1_q;
  // Update operands: residual, 1-k0 and -k1.
  logic signed [31:0] res_q, g0_q, g2_q;

  akf_pkg::state_e state_q, state_d;
  logic [5:0] step_q, step_d;

  // Shared multiplier: operand select is combinational, product registered.
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod_q;
  logic signed [31:0] pr;
  assign pr = akf_pkg::qround(prod_q);

  // Shared restoring divider: |num|*2^16 / |den|, one quotient bit a cycle.
  logic [47:0] dq_q;      // dividend shifting into quotient
  logic [32:0] drem_q;
  logic [31:0] dden_q;
  logic        dneg_q;
  logic [5:0]  dcnt_q;
  logic        dsel_q;    // 0: k0, 1: k1
  logic [33:0] dtrial;
  assign dtrial = {drem_q, dq_q[47]} - {2'b0, dden_q};

  logic signed [31:0] s_val;
  always_comb begin
    s_val = akf_pkg::qadd(p00_q, r_q);
    if (s_val < akf_pkg::SFloor) s_val = akf_pkg::SFloor;
  end

  // Operand schedule: step n issues a multiply whose rounded result is pr at step n+1.
  always_comb begin
    ma = '0;
    mb = '0;
    if (!kind_q) begin
      case (step_q)
        6'd0:  begin ma = vel_q; mb = dt_q; end
        6'd1:  begin ma = akf_pkg::QHalf; mb = acc_q; end
        6'd2:  begin ma = pr; mb = dt_q; end
        6'd3:  begin ma = pr; mb = dt_q; end
        6'd4:  begin ma = acc_q; mb = dt_q; end
        // FP = F*P
        6'd5:  begin ma = f00_q; mb = p00_q; end
        6'd6:  begin ma = f01_q; mb = p10_q; end
        6'd7:  begin ma = f00_q; mb = p01_q; end
        6'd8:  begin ma = f01_q; mb = p11_q; end
        6'd9:  begin ma = f10_q; mb = p00_q; end
        6'd10: begin ma = f11_q; mb = p10_q; end
        6'd11: begin ma = f10_q; mb = p01_q; end
        6'd12: begin ma = f11_q; mb = p11_q; end
        // FPF^T: ft = [f00 f10; f01 f11]
        6'd13: begin ma = t0_q; mb = f00_q; end
        6'd14: begin ma = t1_q; mb = f01_q; end
        6'd15: begin ma = t0_q; mb = f10_q; end
        6'd16: begin ma = t1_q; mb = f11_q; end
        6'd17: begin ma = t2_q; mb = f00_q; end
        6'd18: begin ma = t3_q; mb = f01_q; end
        6'd19: begin ma = t2_q; mb = f10_q; end
        6'd20: begin ma = t3_q; mb = f11_q; end
        default: ;
      endcase
    end else begin
      case (step_q)
        6'd0: begin ma = k0_q; mb = res_q; end
        6'd1: begin ma = k1_q; mb = res_q; end
        6'd2: begin ma = g0_q; mb = p00_q; end
        6'd3: begin ma = g0_q; mb = p01_q; end
        6'd4: begin ma = g2_q; mb = p00_q; end
        6'd5: begin ma = g2_q; mb = p01_q; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(ma) * 64'(mb);
  end

  logic last_step;
  assign last_step = kind_q ? (step_q == 6'd6) : (step_q == 6'd21);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      akf_pkg::ST_IDLE: begin
        step_d = '0;
        if (in_ch.valid) state_d = in_ch.req_type ? akf_pkg::ST_DIV : akf_pkg::ST_RUN;
      end
      akf_pkg::ST_DIV: begin
        if (dcnt_q == 6'd0 && dsel_q) state_d = akf_pkg::ST_RUN;
      end
      akf_pkg::ST_RUN: begin
        step_d = step_q + 6'd1;
        if (last_step) state_d = akf_pkg::ST_OUT;
      end
      akf_pkg::ST_OUT: begin
        if (out_ch.ready) state_d = akf_pkg::ST_IDLE;
      end
      default: state_d = akf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= akf_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_ch.ready  = (state_q == akf_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_q == akf_pkg::ST_OUT);
  assign out_ch.altitude     = alt_q;
  assign out_ch.velocity     = vel_q;
  assign out_ch.altitude_var = p00_q;

  // Divider start for a numerator.
  function automatic logic [47:0] mag48(input logic signed [31:0] v);
    logic [31:0] m;
    m = v[31] ? 32'(-33'(v)) : v;
    mag48 = {m, 16'b0};
  endfunction

  logic signed [48:0] qsigned;
  assign qsigned = dneg_q ? -49'({1'b0, dq_q}) : 49'({1'b0, dq_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f00_q <= akf_pkg::QOne; f01_q <= '0; f10_q <= '0; f11_q <= akf_pkg::QOne;
      q00_q <= '0; q01_q <= '0; q11_q <= '0; r_q <= akf_pkg::QOne;
      alt_q <= '0; vel_q <= '0;
      p00_q <= '0; p01_q <= '0; p10_q <= '0; p11_q <= '0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (akf_pkg::cfg_reg_e'(cfg_ch.index))
          akf_pkg::REG_TRANS_00: f00_q <= cfg_ch.data;
          akf_pkg::REG_TRANS_01: f01_q <= cfg_ch.data;
          akf_pkg::REG_TRANS_10: f10_q <= cfg_ch.data;
          akf_pkg::REG_TRANS_11: f11_q <= cfg_ch.data;
          akf_pkg::REG_NOISE_00: q00_q <= {1'b0, cfg_ch.data[30:0]};
          akf_pkg::REG_NOISE_01: q01_q <= cfg_ch.data;
          akf_pkg::REG_NOISE_11: q11_q <= {1'b0, cfg_ch.data[30:0]};
          akf_pkg::REG_MEAS_VAR: r_q   <= {1'b0, cfg_ch.data[30:0]};
          default: ;
        endcase
      end
      if (state_q == akf_pkg::ST_RUN) begin
        if (!kind_q) begin
          case (step_q)
            6'd1:  t4_q <= pr;                         // vel*dt
            6'd5:  begin                               // accel*dt, move ready
              vel_q <= akf_pkg::qadd(vel_q, pr);
              alt_q <= akf_pkg::qadd(alt_q, akf_pkg::qadd(t4_q, t5_q));
            end
            6'd4:  t5_q <= pr;                         // half*acc*dt*dt
            6'd6:  t6_q <= pr;
            6'd7:  t0_q <= akf_pkg::qadd(t6_q, pr);
            6'd8:  t6_q <= pr;
            6'd9:  t1_q <= akf_pkg::qadd(t6_q, pr);
            6'd10: t6_q <= pr;
            6'd11: t2_q <= akf_pkg::qadd(t6_q, pr);
            6'd12: t6_q <= pr;
            6'd13: t3_q <= akf_pkg::qadd(t6_q, pr);
            6'd14: t6_q <= pr;
            6'd15: t7_q <= akf_pkg::qadd(t6_q, pr);
            6'd16: t6_q <= pr;
            6'd17: p01_q <= akf_pkg::qadd(akf_pkg::qadd(t6_q, pr), q01_q);
            6'd18: t6_q <= pr;
            6'd19: p10_q <= akf_pkg::qadd(akf_pkg::qadd(t6_q, pr), q01_q);
            6'd20: t6_q <= pr;
            6'd21: begin
              p11_q <= akf_pkg::qadd(akf_pkg::qadd(t6_q, pr), q11_q);
              p00_q <= akf_pkg::qadd(t7_q, q00_q);
            end
            default: ;
          endcase
        end else begin
          case (step_q)
            6'd1: alt_q <= akf_pkg::qadd(alt_q, pr);
            6'd2: vel_q <= akf_pkg::qadd(vel_q, pr);
            6'd3: t0_q <= pr;
            6'd4: t1_q <= pr;
            6'd5: t2_q <= pr;
            6'd6: begin
              // G = [1-k0, 0; -k1, 1]: row 1 adds P row 1 itself
              p00_q <= t0_q;
              p01_q <= t1_q;
              p10_q <= akf_pkg::qadd(t2_q, p10_q);
              p11_q <= akf_pkg::qadd(pr, p11_q);
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Latch request and drive the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
      dsel_q <= 1'b0;
      kind_q <= 1'b0;
    end else if (state_q == akf_pkg::ST_IDLE && in_ch.valid) begin
      kind_q <= in_ch.req_type;
      dt_q   <= {14'b0, in_ch.time_step};
      acc_q  <= in_ch.accel;
      meas_q <= in_ch.meas_altitude;
      dq_q   <= mag48(p00_q);
      drem_q <= '0;
      dden_q <= s_val;
      dneg_q <= p00_q[31];
      dcnt_q <= 6'd48;
      dsel_q <= 1'b0;
    end else if (state_q == akf_pkg::ST_DIV) begin
      if (dcnt_q != 6'd0) begin
        if (!dtrial[33]) begin
          drem_q <= dtrial[32:0];
          dq_q   <= {dq_q[46:0], 1'b1};
        end else begin
          drem_q <= {drem_q[31:0], dq_q[47]};
          dq_q   <= {dq_q[46:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 6'd1;
      end else begin
        if (!dsel_q) begin
          k0_q   <= akf_pkg::sat32(66'(qsigned));
          dq_q   <= mag48(p10_q);
          drem_q <= '0;
          dneg_q <= p10_q[31];
          dcnt_q <= 6'd48;
          dsel_q <= 1'b1;
        end else begin
          k1_q  <= akf_pkg::sat32(66'(qsigned));
          res_q <= akf_pkg::qsub(meas_q, alt_q);
          g0_q  <= akf_pkg::qsub(akf_pkg::QOne, k0_q);
          g2_q  <= akf_pkg::qsub(32'sd0, akf_pkg::sat32(66'(qsigned)));
        end
      end
    end
  end

  ap_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != akf_pkg::ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  ap_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.altitude_var)))
    else $error("result dropped");
  ap_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == akf_pkg::ST_DIV) |-> (dcnt_q <= 6'd48)) else $error("divider count");

endmodule

### tb/sv/akf_tb_checker.sv
`timescale 1ns / 1ps
// Filter-state predictor and result comparator for the altitude Kalman filter core.
// Watches the input, output and register channels; depends on akf_pkg and akf_if.
module akf_tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  akf_in_if.sink      in_mon,
  akf_out_if.sink     out_mon,
  akf_cfg_if.sink     cfg_mon,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic signed [31:0] alt;
    logic signed [31:0] vel;
    logic signed [31:0] var00;
  } est_t;

  logic signed [31:0] f00, f01, f10, f11, q00, q01, q11, r_var;
  logic signed [31:0] alt_m, vel_m;
  logic signed [31:0] pm [4];
  est_t est_q [$];

  function automatic logic signed [31:0] clip(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] add_s(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return clip(longint'(a) + longint'(b));
  endfunction

  // Round half up: arithmetic shift floors.
  function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b) + 32768;
    return clip(p >>> 16);
  endfunction

  // Truncate toward zero, then clip.
  function automatic logic signed [31:0] div_q(input logic signed [31:0] n,
                                               input logic signed [31:0] d);
    return clip((longint'(n) * 65536) / longint'(d));
  endfunction

  task automatic mat2(input logic signed [31:0] a [4], input logic signed [31:0] b [4],
                      output logic signed [31:0] c [4]);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        c[i*2+j] = add_s(mul_q(a[i*2], b[j]), mul_q(a[i*2+1], b[2+j]));
  endtask

  task automatic step_filter(input logic kind, input logic [17:0] dt_u,
                             input logic signed [31:0] acc,
                             input logic signed [31:0] meas);
    logic signed [31:0] dt, move, s, k0, k1, resid;
    logic signed [31:0] f [4], ft [4], fp [4], fpf [4], g [4];
    est_t e;
    if (kind == 1'b0) begin
      dt = {14'd0, dt_u};
      move = add_s(mul_q(vel_m, dt),
                   mul_q(mul_q(mul_q(akf_pkg::QHalf, acc), dt), dt));
      alt_m = add_s(alt_m, move);
      vel_m = add_s(vel_m, mul_q(acc, dt));
      f = '{f00, f01, f10, f11};
      ft = '{f00, f10, f01, f11};
      mat2(f, pm, fp);
      mat2(fp, ft, fpf);
      pm[0] = add_s(fpf[0], q00);
      pm[1] = add_s(fpf[1], q01);
      pm[2] = add_s(fpf[2], q01);
      pm[3] = add_s(fpf[3], q11);
    end else begin
      s = add_s(pm[0], r_var);
      if (s < akf_pkg::SFloor) s = akf_pkg::SFloor;
      k0 = div_q(pm[0], s);
      k1 = div_q(pm[2], s);
      resid = clip(longint'(meas) - longint'(alt_m));
      alt_m = add_s(alt_m, mul_q(k0, resid));
      vel_m = add_s(vel_m, mul_q(k1, resid));
      g = '{clip(longint'(akf_pkg::QOne) - longint'(k0)), 32'sd0, clip(-longint'(k1)),
            akf_pkg::QOne};
      mat2(g, pm, fp);
      pm = fp;
    end
    e.alt = alt_m;
    e.vel = vel_m;
    e.var00 = pm[0];
    est_q.push_back(e);
  endtask

  assign pending_o = est_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    est_t e;
    if (!rst_ni) begin
      f00 <= akf_pkg::QOne; f01 <= '0; f10 <= '0; f11 <= akf_pkg::QOne;
      q00 <= '0; q01 <= '0; q11 <= '0; r_var <= akf_pkg::QOne;
      alt_m = '0; vel_m = '0;
      pm = '{0, 0, 0, 0};
      est_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (akf_pkg::cfg_reg_e'(cfg_mon.index))
          akf_pkg::REG_TRANS_00: f00 <= cfg_mon.data;
          akf_pkg::REG_TRANS_01: f01 <= cfg_mon.data;
          akf_pkg::REG_TRANS_10: f10 <= cfg_mon.data;
          akf_pkg::REG_TRANS_11: f11 <= cfg_mon.data;
          akf_pkg::REG_NOISE_00: q00 <= {1'b0, cfg_mon.data[30:0]};
          akf_pkg::REG_NOISE_01: q01 <= cfg_mon.data;
          akf_pkg::REG_NOISE_11: q11 <= {1'b0, cfg_mon.data[30:0]};
          akf_pkg::REG_MEAS_VAR: r_var <= {1'b0, cfg_mon.data[30:0]};
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (est_q.size() == 0) begin
          $error("unexpected result word alt=%h", out_mon.altitude);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = est_q.pop_front();
          if (out_mon.altitude !== e.alt || out_mon.velocity !== e.vel ||
              out_mon.altitude_var !== e.var00) begin
            if (out_mon.altitude !== e.alt)
              $error("altitude exp %h got %h", e.alt, out_mon.altitude);
            if (out_mon.velocity !== e.vel)
              $error("velocity exp %h got %h", e.vel, out_mon.velocity);
            if (out_mon.altitude_var !== e.var00)
              $error("altitude_var exp %h got %h", e.var00, out_mon.altitude_var);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        step_filter(in_mon.req_type, in_mon.time_step, in_mon.accel, in_mon.meas_altitude);
    end
  end
endmodule

### tb/sv/altitude_kalman_filter_2state_core_tb.sv
`timescale 1ns / 1ps
// Top of the altitude Kalman filter core testbench: clock, reset, stimulus, verdict.
// Depends on akf_pkg, akf_if, akf_tb_checker and the core RTL.
module altitude_kalman_filter_2state_core_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   recv_hold = 1'b0;
  bit   hold_done = 1'b0;

  akf_in_if  in_ch ();
  akf_out_if out_ch ();
  akf_cfg_if cfg_ch ();

  altitude_kalman_filter_2state_core uut (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_ch (in_ch), .out_ch (out_ch), .cfg_ch (cfg_ch)
  );

  akf_tb_checker chk (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_mon (in_ch), .out_mon (out_ch),
    .cfg_mon (cfg_ch), .fail_count_o (fail_count), .pending_o (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop; a slow correct run needs well under a tenth of this.
  initial begin
    #60ms;
    $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, or a long hold-off while the sender keeps going.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_hold) out_ch.ready <= 1'b0;
      else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted in cycles here so the core backs up.
  initial begin
    wait (hold_done);
    recv_hold = 1'b1;
    repeat (400) @(negedge clk_i);
    recv_hold = 1'b0;
  end

  // Drive one input word; hold it until accepted. Drop any register write
  // left on the bus; the next word or drain drops valid.
  task automatic send_word(input logic kind, input logic [17:0] dt,
                           input logic signed [31:0] acc, input logic signed [31:0] meas);
    cfg_ch.valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.time_step <= dt;
    in_ch.accel <= acc;
    in_ch.meas_altitude <= meas;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Write one register; the next word drops valid.
  task automatic write_reg(input akf_pkg::cfg_reg_e idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
  endtask

  // Wait until every expected word is back, then let the core settle.
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  // Small, tame settings keep the filter away from constant saturation; wild uses full random words.
  task automatic write_all(input bit wild);
    write_reg(akf_pkg::REG_TRANS_00, wild ? $urandom() : 32'h10000 + $urandom_range(4096));
    write_reg(akf_pkg::REG_TRANS_01, wild ? $urandom() : $urandom_range(8192));
    write_reg(akf_pkg::REG_TRANS_10, wild ? $urandom() : $urandom_range(255));
    write_reg(akf_pkg::REG_TRANS_11, wild ? $urandom() : 32'h10000 - $urandom_range(2048));
    write_reg(akf_pkg::REG_NOISE_00, wild ? $urandom() : $urandom_range(20000));
    write_reg(akf_pkg::REG_NOISE_01, wild ? $urandom() : $urandom_range(2000));
    write_reg(akf_pkg::REG_NOISE_11, wild ? $urandom() : $urandom_range(20000));
    write_reg(akf_pkg::REG_MEAS_VAR, wild ? $urandom() : $urandom_range(200000));
  endtask

  task automatic random_words(input int n);
    logic signed [31:0] acc, meas;
    logic [17:0] dt;
    for (int i = 0; i < n; i++) begin
      dt = ($urandom_range(9) == 0) ? 18'($urandom()) : 18'($urandom_range(6554));
      acc = ($urandom_range(9) == 0) ? $urandom() : $signed($urandom_range(1310720)) - 655360;
      meas = ($urandom_range(9) == 0) ? $urandom() : $signed($urandom_range(6553600)) - 3276800;
      send_word($urandom_range(2) == 0, dt, acc, meas);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = 1'b0;
    in_ch.time_step = '0;
    in_ch.accel = '0;
    in_ch.meas_altitude = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: update on zero covariance hits the variance floor first.
    write_reg(akf_pkg::REG_MEAS_VAR, 32'd0);
    send_word(1'b1, 18'd0, 32'sd0, 32'sh7fffffff);
    send_word(1'b0, 18'h3ffff, 32'sh7fffffff, 32'sd0);
    send_word(1'b0, 18'h3ffff, 32'sh80000000, 32'sd0);
    send_word(1'b0, 18'd0, 32'sd0, 32'sd0);
    send_word(1'b1, 18'd0, 32'sd0, 32'sh80000000);
    drain();
    write_reg(akf_pkg::REG_TRANS_00, 32'h7fffffff);
    write_reg(akf_pkg::REG_TRANS_01, 32'h80000000);
    write_reg(akf_pkg::REG_TRANS_10, 32'h7fffffff);
    write_reg(akf_pkg::REG_TRANS_11, 32'h80000000);
    write_reg(akf_pkg::REG_NOISE_00, 32'hffffffff);
    write_reg(akf_pkg::REG_NOISE_01, 32'h80000000);
    write_reg(akf_pkg::REG_NOISE_11, 32'h7fffffff);
    write_reg(akf_pkg::REG_MEAS_VAR, 32'h7fffffff);
    send_word(1'b0, 18'd65536, 32'sd65536, 32'sd0);
    send_word(1'b1, 18'd0, 32'sd0, 32'sd1000);
    send_word(1'b0, 18'd131072, -32'sd65536, 32'sd0);
    send_word(1'b1, 18'h3ffff, 32'sh7fffffff, -32'sd5);
    drain();

    // Random phases: receiver idles more, then sender, then neither.
    send_idle_pct = 17; recv_idle_pct = 57;
    write_all(1'b0);
    random_words(500);
    drain();
    send_idle_pct = 57; recv_idle_pct = 17;
    write_all(1'b1);
    random_words(100);
    drain();
    write_all(1'b0);
    random_words(500);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_all(1'b0);
    hold_done = 1'b1;
    random_words(600);
    drain();

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
